// File: rtl/utf8_dec_pkg.sv
package utf8_dec_pkg;

    // Lead byte classes
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_CODE  = 8'hF0;

    // Sequence length codes (length minus one)
    localparam logic [1:0] SEQ_TWO     = 2'd1;
    localparam logic [1:0] SEQ_THREE   = 2'd2;
    localparam logic [1:0] SEQ_FOUR    = 2'd3;

    // Surrogate construction
    localparam logic [25:0] SUPP_BASE  = 26'h10000;
    localparam logic [15:0] HIGH_SURR  = 16'hD800;
    localparam logic [15:0] LOW_SURR   = 16'hDC00;

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_last;
    } unit_t;

    // Units produced by one decoded byte, in order u0 then u1
    typedef struct packed {
        logic [1:0] count;
        unit_t      u0;
        unit_t      u1;
    } push_t;

endpackage

// File: rtl/utf8_dec_if.sv
interface utf8_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface utf8_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        run_last;

    modport source (output valid, output code_unit, output run_last, input ready);
    modport sink   (input valid, input code_unit, input run_last, output ready);
endinterface

// File: rtl/utf8_to_utf16_decoder.sv
// UTF-8 to UTF-16 stream decoder. Takes one UTF-8 byte per item on byte_in and
// delivers UTF-16 code units on unit_out, one per item, with run_last set on the
// last unit caused by a byte. A byte is registered, decoded against the open
// sequence, and its units (one, or two surrogate halves for a four-byte
// sequence) go to a four-entry result queue; the block accepts one byte every
// cycle while the queue has space for two units, so throughput is one byte per
// cycle, and a byte passes the input register and then the queue before its units appear.
// Invalid lead bytes produce nothing, continuation bytes are not checked, and
// end_of_string discards an unfinished sequence.
module utf8_to_utf16_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    utf8_byte_if.sink   byte_in,
    utf8_unit_if.source unit_out
);

    utf8_dec_pkg::push_t push;
    logic                room;

    utf8_dec_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .room    (room),
        .push    (push)
    );

    utf8_dec_outq u_outq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .unit_out (unit_out)
    );

endmodule

// File: rtl/utf8_dec_decode.sv
module utf8_dec_decode
(
    input  logic                    clk,
    input  logic                    rst_n,
    utf8_byte_if.sink               byte_in,
    input  logic                    room,
    output utf8_dec_pkg::push_t     push
);

    logic        v_reg;
    logic [7:0]  byte_reg;
    logic        eos_reg;

    logic [1:0]  rem_reg, rem_next;
    logic [20:0] part_reg, part_next;
    logic [1:0]  seq_reg, seq_next;

    logic        advance;
    logic [20:0] cp;
    logic [1:0]  rem_dec;
    logic [25:0] supp;

    assign advance       = v_reg && room;
    assign byte_in.ready = !v_reg || room;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            v_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            byte_reg <= byte_in.in_byte;
            eos_reg  <= byte_in.end_of_string;
        end
    end

    // Sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            part_reg <= '0;
            seq_reg  <= '0;
        end
        else if (advance)
        begin
            rem_reg  <= rem_next;
            part_reg <= part_next;
            seq_reg  <= seq_next;
        end
    end

    // Shift-or accumulation and surrogate split
    assign cp      = {part_reg[14:0], byte_reg[5:0]};
    assign rem_dec = rem_reg - 2'd1;
    assign supp    = {5'd0, cp} - utf8_dec_pkg::SUPP_BASE;

    always_comb
    begin
        rem_next   = rem_reg;
        part_next  = part_reg;
        seq_next   = seq_reg;
        push.count = 2'd0;
        push.u0    = '{code_unit: cp[15:0], run_last: 1'b1};
        push.u1    = '{code_unit: utf8_dec_pkg::LOW_SURR | {6'd0, supp[9:0]},
                       run_last: 1'b1};

        if (rem_reg == 2'd0)
        begin
            // lead position
            if (!byte_reg[7])
            begin
                push.count = 2'd1;
                push.u0    = '{code_unit: {8'd0, byte_reg}, run_last: 1'b1};
            end
            else if ((byte_reg & utf8_dec_pkg::LEAD2_MASK) == utf8_dec_pkg::LEAD2_CODE)
            begin
                part_next = {16'd0, byte_reg[4:0]};
                rem_next  = 2'd1;
                seq_next  = utf8_dec_pkg::SEQ_TWO;
            end
            else if ((byte_reg & utf8_dec_pkg::LEAD3_MASK) == utf8_dec_pkg::LEAD3_CODE)
            begin
                part_next = {17'd0, byte_reg[3:0]};
                rem_next  = 2'd2;
                seq_next  = utf8_dec_pkg::SEQ_THREE;
            end
            else if ((byte_reg & utf8_dec_pkg::LEAD4_MASK) == utf8_dec_pkg::LEAD4_CODE)
            begin
                part_next = {18'd0, byte_reg[2:0]};
                rem_next  = 2'd3;
                seq_next  = utf8_dec_pkg::SEQ_FOUR;
            end
        end
        else
        begin
            // continuation byte, taken unchecked
            part_next = cp;
            rem_next  = rem_dec;
            if (rem_dec == 2'd0)
            begin
                if (seq_reg == utf8_dec_pkg::SEQ_FOUR)
                begin
                    push.count = 2'd2;
                    push.u0    = '{code_unit: utf8_dec_pkg::HIGH_SURR | supp[25:10],
                                   run_last: 1'b0};
                end
                else
                begin
                    push.count = 2'd1;
                end
                part_next = '0;
                seq_next  = '0;
            end
        end

        // end of string drops any open sequence
        if (eos_reg)
        begin
            rem_next  = '0;
            part_next = '0;
            seq_next  = '0;
        end

        if (!advance)
        begin
            push.count = 2'd0;
        end
    end

endmodule

// File: rtl/utf8_dec_outq.sv
module utf8_dec_outq
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  utf8_dec_pkg::push_t     push,
    output logic                    room,
    utf8_unit_if.source             unit_out
);

    utf8_dec_pkg::unit_t                   mem_reg [utf8_dec_pkg::QDEPTH];
    logic [utf8_dec_pkg::QPTR_W-1:0]      head_reg, head_next;
    logic [utf8_dec_pkg::QPTR_W-1:0]      tail_reg, tail_next;
    logic [utf8_dec_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;
    logic [utf8_dec_pkg::QPTR_W-1:0]      tail_plus1;
    logic                                 pop;

    // room for a full two-unit push
    assign room = cnt_reg <= utf8_dec_pkg::QCNT_W'(utf8_dec_pkg::QDEPTH - 2);

    assign pop                = unit_out.valid && unit_out.ready;
    assign unit_out.valid     = cnt_reg != '0;
    assign unit_out.code_unit = mem_reg[head_reg].code_unit;
    assign unit_out.run_last  = mem_reg[head_reg].run_last;
    assign tail_plus1         = tail_reg + 1'b1;

    always_comb
    begin
        head_next = head_reg + {{(utf8_dec_pkg::QPTR_W-1){1'b0}}, pop};
        tail_next = tail_reg + utf8_dec_pkg::QPTR_W'(push.count);
        cnt_next  = cnt_reg + utf8_dec_pkg::QCNT_W'(push.count)
                    - {{(utf8_dec_pkg::QCNT_W-1){1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[tail_reg] <= push.u0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[tail_plus1] <= push.u1;
        end
    end

endmodule
